// ===== rtl/srw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence replay window package
// Shared types and constants for the anti-replay window block.
// ----------------------------------------------------------------------------
package srw_pkg;

   localparam int SEQ_WIDTH  = 16;
   localparam int HIST_WIDTH = 32;

   typedef logic [SEQ_WIDTH-1:0]  seq_type;
   typedef logic [HIST_WIDTH-1:0] hist_type;

   typedef enum logic {
      OP_RECORD = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   // One request transaction as it travels through the pipeline.
   typedef struct packed {
      op_type  operation;
      seq_type seq_number;
   } req_type;

   // One response transaction.
   typedef struct packed {
      logic     verdict;
      seq_type  newest_seq;
      hist_type window_bits;
   } rsp_type;

endpackage

// ===== rtl/srw_channels_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence replay window channels
// Valid/ready interfaces for the request and response channels.
// ----------------------------------------------------------------------------
interface srw_req_if;
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic [srw_pkg::SEQ_WIDTH-1:0] seq_number;

   modport source (output valid, output operation, output seq_number, input ready);
   modport sink   (input valid, input operation, input seq_number, output ready);
endinterface

interface srw_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           verdict;
   logic [srw_pkg::SEQ_WIDTH-1:0]  newest_seq;
   logic [srw_pkg::HIST_WIDTH-1:0] window_bits;

   modport source (output valid, output verdict, output newest_seq, output window_bits,
                   input ready);
   modport sink   (input valid, input verdict, input newest_seq, input window_bits,
                   output ready);
endinterface

// ===== rtl/srw_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence replay window state
// Holds the started flag, newest sequence number and arrival history, and
// combinationally computes the verdict and next state for one transaction.
// ----------------------------------------------------------------------------
module srw_window #(
   parameter int WINDOW = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  srw_pkg::req_type item,
   output srw_pkg::rsp_type result
);

   localparam logic [srw_pkg::HIST_WIDTH:0] MaskWide =
      (33'd1 << WINDOW) - 33'd1;
   localparam srw_pkg::hist_type WinMask = MaskWide[srw_pkg::HIST_WIDTH-1:0];
   localparam srw_pkg::seq_type  WinSize = srw_pkg::SEQ_WIDTH'(WINDOW);

   logic              started_ff, started_in;
   srw_pkg::seq_type  newest_ff, newest_in;
   srw_pkg::hist_type hist_ff, hist_in;

   srw_pkg::seq_type  fwd_dist;
   srw_pkg::seq_type  back_dist;
   srw_pkg::seq_type  back_less;
   logic              is_newer;
   logic              in_window;
   logic [4:0]        shamt;
   srw_pkg::hist_type back_bit;
   srw_pkg::hist_type shifted;
   logic              verdict;

   always_comb begin
      fwd_dist  = item.seq_number - newest_ff;
      back_dist = newest_ff - item.seq_number;
      back_less = back_dist - 16'd1;
      // Serial-number order: the half-way distance counts as older.
      is_newer  = (fwd_dist != '0) && !fwd_dist[srw_pkg::SEQ_WIDTH-1];
      in_window = (back_dist != '0) && (back_dist <= WinSize);
      back_bit  = srw_pkg::hist_type'(1) << back_less[4:0];
      shamt     = fwd_dist[4:0];
      // The old newest lands at bit d-1 after the shift.
      shifted   = ((hist_ff << shamt) | (srw_pkg::hist_type'(1) << (shamt - 5'd1)))
                  & WinMask;

      started_in = started_ff;
      newest_in  = newest_ff;
      hist_in    = hist_ff;
      verdict    = 1'b0;

      case (item.operation)
         srw_pkg::OP_RECORD: begin
            if (!started_ff) begin
               started_in = 1'b1;
               newest_in  = item.seq_number;
               hist_in    = '0;
               verdict    = 1'b1;
            end else if (is_newer) begin
               newest_in = item.seq_number;
               hist_in   = (fwd_dist >= WinSize) ? '0 : shifted;
               verdict   = 1'b1;
            end else if (in_window && ((hist_ff & back_bit) == '0)) begin
               hist_in = hist_ff | back_bit;
               verdict = 1'b1;
            end
         end
         default: begin
            verdict = started_ff &&
                      ((item.seq_number == newest_ff) ||
                       (!is_newer && in_window && ((hist_ff & back_bit) != '0)));
         end
      endcase

      result.verdict     = verdict;
      result.newest_seq  = newest_in;
      result.window_bits = hist_in & WinMask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         newest_ff  <= '0;
         hist_ff    <= '0;
      end else if (step) begin
         started_ff <= started_in;
         newest_ff  <= newest_in;
         hist_ff    <= hist_in;
      end
   end

endmodule

// ===== rtl/sequence_replay_window_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence replay window unit
// Anti-replay filter over 16-bit wrapping sequence numbers with a sliding
// window of earlier arrivals; records arrivals or answers queries.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload                                 Handshake
// req_if    in         operation, seq_number                   valid/ready
// rsp_if    out        verdict, newest_seq, window_bits        valid/ready
//
// One transaction per cycle sustained while rsp_if.ready holds. The response
// of an accepted request passes the request register, then the response
// register. Each transaction updates the window as it moves between the two
// registers, so it sees its predecessor's state. Reset is synchronous and
// clears state and valids. A stalled response holds its register; the request
// register still takes one more transaction while the response waits.
// ----------------------------------------------------------------------------
module sequence_replay_window_unit #(
   parameter int WINDOW = 32
) (
   input  logic      clock,
   input  logic      reset,
   srw_req_if.sink   req_if,
   srw_rsp_if.source rsp_if
);

   localparam logic [srw_pkg::HIST_WIDTH:0] MaskWide =
      (33'd1 << WINDOW) - 33'd1;
   localparam srw_pkg::hist_type WinMask = MaskWide[srw_pkg::HIST_WIDTH-1:0];

   logic             req_valid_ff;
   srw_pkg::req_type req_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   srw_pkg::rsp_type rsp_data_ff;
   srw_pkg::rsp_type result;
   logic             advance;
   logic             req_take;

   assign advance  = req_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;
   assign req_if.ready = !req_valid_ff || advance;

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_if.ready) begin
            req_valid_ff <= req_if.valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_data_ff.operation  <= srw_pkg::op_type'(req_if.operation);
         req_data_ff.seq_number <= req_if.seq_number;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   srw_window #(
      .WINDOW (WINDOW)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (req_data_ff),
      .result (result)
   );

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.verdict     = rsp_data_ff.verdict;
   assign rsp_if.newest_seq  = rsp_data_ff.newest_seq;
   assign rsp_if.window_bits = rsp_data_ff.window_bits;

`ifndef ASSERT_OFF
   a_window_masked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.window_bits & ~WinMask) == '0))
      else $error("window bits set beyond the window size");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("response register empty after a pipeline move");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |-> req_if.ready)
      else $error("request channel stalled with an empty request register");
`endif

endmodule

// ===== dv/tb_sequence_replay_window_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence replay window unit testbench
// Drives record and query transactions through the request channel and
// checks every response against a cycle-free model of the anti-replay window
// or a pinned row's fixed response. A directed table covers start-up,
// wrap-around, the window edges and the half-range distance. Random traffic
// then follows the newest sequence number closely so that the window fills,
// shifts and clears. Request idling and response stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_sequence_replay_window_unit;

   localparam int WINDOW        = 32;
   localparam int PHASE_ITEMS   = 275;
   localparam int DRAIN_CYCLES  = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam logic PINNED      = 1'b1;
   localparam logic OPEN        = 1'b0;

   // One row of the directed table. When pinned is set, want is the response
   // that the hardware must return; otherwise the window model decides.
   typedef struct packed {
      srw_pkg::op_type  op;
      srw_pkg::seq_type seq;
      logic             pinned;
      srw_pkg::rsp_type want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;

   srw_req_if req_ch ();
   srw_rsp_if rsp_ch ();

   sequence_replay_window_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #5 clock = ~clock;

   // Window model state.
   logic              win_started;
   srw_pkg::seq_type  win_newest;
   srw_pkg::hist_type win_history;

   // Sideband that travels with the request currently on the channel.
   logic             req_pinned;
   srw_pkg::rsp_type req_pinned_rsp;

   srw_pkg::rsp_type window_reports_due[$];
   script_row_type   directed_rows[0:23];

   int send_idle_pct;
   int rsp_stall_pct;
   int mismatch_count;
   int record_count;
   int query_count;
   int accepted_count;
   int seen_count;
   int quiet_cycles;

   // Newest sequence number as the sender sees it, used to aim traffic.
   logic             lead_started;
   srw_pkg::seq_type lead_seq;

   function automatic srw_pkg::rsp_type step_replay_window(srw_pkg::op_type op,
                                                           srw_pkg::seq_type seq);
      srw_pkg::seq_type ahead;
      srw_pkg::seq_type behind;
      logic [4:0]       slot;
      logic             verdict;
      srw_pkg::rsp_type report;
      ahead   = seq - win_newest;
      behind  = win_newest - seq;
      slot    = behind[4:0] - 5'd1;
      verdict = 1'b0;
      if (op == srw_pkg::OP_RECORD) begin
         if (!win_started) begin
            win_started = 1'b1;
            win_newest  = seq;
            win_history = '0;
            verdict     = 1'b1;
         end else if (ahead != 0 && ahead <= 16'h7FFF) begin
            // A shift of a whole window or more drops everything, including
            // the previous newest number.
            if (ahead >= WINDOW)
               win_history = '0;
            else
               win_history = (win_history << ahead) |
                             (srw_pkg::hist_type'(1) << (ahead - 1));
            win_newest = seq;
            verdict    = 1'b1;
         end else if (behind != 0 && behind <= WINDOW && !win_history[slot]) begin
            win_history[slot] = 1'b1;
            verdict = 1'b1;
         end
      end else begin
         if (!win_started)
            verdict = 1'b0;
         else if (ahead == 0)
            verdict = 1'b1;
         else if (ahead <= 16'h7FFF)
            verdict = 1'b0;
         else if (behind <= WINDOW)
            verdict = win_history[slot];
      end
      report.verdict     = verdict;
      report.newest_seq  = win_newest;
      report.window_bits = win_history;
      return report;
   endfunction

   // Offers one transaction, after a random number of idle cycles, and
   // returns at the edge where it is accepted.
   task automatic send_req(srw_pkg::op_type op, srw_pkg::seq_type seq, logic pinned,
                           srw_pkg::rsp_type want);
      srw_pkg::seq_type ahead;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.operation  <= op;
      req_ch.seq_number <= seq;
      req_pinned        <= pinned;
      req_pinned_rsp    <= want;
      do
         @(posedge clock);
      while (!req_ch.ready);
      ahead = seq - lead_seq;
      if (op == srw_pkg::OP_RECORD &&
          (!lead_started || (ahead != 0 && ahead <= 16'h7FFF))) begin
         lead_started = 1'b1;
         lead_seq     = seq;
      end
   endtask

   // Mostly traffic near the newest number: in-order arrivals, late and
   // repeated ones, queries across the window, jumps of every size, and a
   // share of fully random transactions.
   task automatic send_random_traffic(int count);
      int               pick;
      srw_pkg::op_type  op;
      srw_pkg::seq_type seq;
      repeat (count) begin
         pick = $urandom_range(99);
         op   = srw_pkg::OP_RECORD;
         if (pick < 42)
            seq = lead_seq + srw_pkg::seq_type'($urandom_range(1, 3));
         else if (pick < 64)
            seq = lead_seq - srw_pkg::seq_type'($urandom_range(0, 34));
         else if (pick < 79) begin
            op  = srw_pkg::OP_QUERY;
            seq = lead_seq + 16'd3 - srw_pkg::seq_type'($urandom_range(0, 37));
         end else if (pick < 84)
            seq = lead_seq + srw_pkg::seq_type'($urandom_range(4, 40));
         else if (pick < 88)
            seq = lead_seq + srw_pkg::seq_type'($urandom_range(32, 32767));
         else if (pick < 91)
            seq = lead_seq + 16'h8000;
         else begin
            op  = srw_pkg::op_type'($urandom_range(1));
            seq = srw_pkg::seq_type'($urandom_range(16'hFFFF));
         end
         send_req(op, seq, OPEN, '0);
      end
   endtask

   // Holds the request channel quiet until every response is back.
   task automatic wait_for_responses();
      req_ch.valid <= 1'b0;
      do
         @(posedge clock);
      while (window_reports_due.size() != 0);
   endtask

   always @(posedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : scoreboard
      srw_pkg::rsp_type predicted;
      srw_pkg::rsp_type got;
      srw_pkg::rsp_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            predicted = step_replay_window(srw_pkg::op_type'(req_ch.operation),
                                           req_ch.seq_number);
            window_reports_due.push_back(req_pinned ? req_pinned_rsp : predicted);
            if (req_ch.operation == srw_pkg::OP_RECORD) begin
               record_count++;
               accepted_count += predicted.verdict;
            end else begin
               query_count++;
               seen_count += predicted.verdict;
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.verdict     = rsp_ch.verdict;
            got.newest_seq  = rsp_ch.newest_seq;
            got.window_bits = rsp_ch.window_bits;
            if (window_reports_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: response with none expected: verdict %0b newest %h window %h",
                        $time, got.verdict, got.newest_seq, got.window_bits);
            end else begin
               want = window_reports_due.pop_front();
               if (got.verdict !== want.verdict || got.newest_seq !== want.newest_seq ||
                   got.window_bits !== want.window_bits) begin
                  mismatch_count++;
                  $display("%0t: verdict exp %0b act %0b, newest_seq exp %h act %h",
                           $time, want.verdict, got.verdict, want.newest_seq,
                           got.newest_seq);
                  $display("%0t: window_bits exp %h act %h",
                           $time, want.window_bits, got.window_bits);
               end
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      int row;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.operation  = srw_pkg::OP_RECORD;
      req_ch.seq_number = '0;
      req_pinned        = OPEN;
      req_pinned_rsp    = '0;
      win_started       = 1'b0;
      win_newest        = '0;
      win_history       = '0;
      lead_started      = 1'b0;
      lead_seq          = '0;
      send_idle_pct     = 0;
      rsp_stall_pct     = 0;
      mismatch_count    = 0;
      record_count      = 0;
      query_count       = 0;
      accepted_count    = 0;
      seen_count        = 0;

      // Queries before the first record, start-up right below the wrap point,
      // a wrapping shift, late arrivals at both window edges, the half-range
      // distance, shifts of 31, 32 and 32767, and an older number across zero.
      directed_rows[0]  = {srw_pkg::OP_QUERY,  16'h0000, PINNED, 1'b0, 16'h0000, 32'h0000_0000};
      directed_rows[1]  = {srw_pkg::OP_QUERY,  16'hFFFF, PINNED, 1'b0, 16'h0000, 32'h0000_0000};
      directed_rows[2]  = {srw_pkg::OP_RECORD, 16'hFFF0, PINNED, 1'b1, 16'hFFF0, 32'h0000_0000};
      directed_rows[3]  = {srw_pkg::OP_RECORD, 16'hFFF0, PINNED, 1'b0, 16'hFFF0, 32'h0000_0000};
      directed_rows[4]  = {srw_pkg::OP_QUERY,  16'hFFF0, PINNED, 1'b1, 16'hFFF0, 32'h0000_0000};
      directed_rows[5]  = {srw_pkg::OP_RECORD, 16'hFFF1, PINNED, 1'b1, 16'hFFF1, 32'h0000_0001};
      directed_rows[6]  = {srw_pkg::OP_RECORD, 16'h0001, OPEN,   1'b0, 16'h0000, 32'h0000_0000};
      directed_rows[7]  = {srw_pkg::OP_RECORD, 16'hFFF5, OPEN,   1'b0, 16'h0000, 32'h0000_0000};
      directed_rows[8]  = {srw_pkg::OP_RECORD, 16'hFFF5, OPEN,   1'b0, 16'h0000, 32'h0000_0000};
      directed_rows[9]  = {srw_pkg::OP_QUERY,  16'hFFF5, OPEN,   1'b0, 16'h0000, 32'h0000_0000};
      directed_rows[10] = {srw_pkg::OP_QUERY,  16'hFFE1, OPEN,   1'b0, 16'h0000, 32'h0000_0000};
      directed_rows[11] = {srw_pkg::OP_RECORD, 16'hFFE1, OPEN,   1'b0, 16'h0000, 32'h0000_0000};
      directed_rows[12] = {srw_pkg::OP_RECORD, 16'hFFE0, OPEN,   1'b0, 16'h0000, 32'h0000_0000};
      directed_rows[13] = {srw_pkg::OP_QUERY,  16'h0002, OPEN,   1'b0, 16'h0000, 32'h0000_0000};
      directed_rows[14] = {srw_pkg::OP_RECORD, 16'h8001, OPEN,   1'b0, 16'h0000, 32'h0000_0000};
      directed_rows[15] = {srw_pkg::OP_QUERY,  16'h8001, OPEN,   1'b0, 16'h0000, 32'h0000_0000};
      directed_rows[16] = {srw_pkg::OP_RECORD, 16'h0020, OPEN,   1'b0, 16'h0000, 32'h0000_0000};
      directed_rows[17] = {srw_pkg::OP_RECORD, 16'h0040, PINNED, 1'b1, 16'h0040, 32'h0000_0000};
      directed_rows[18] = {srw_pkg::OP_RECORD, 16'h803F, PINNED, 1'b1, 16'h803F, 32'h0000_0000};
      directed_rows[19] = {srw_pkg::OP_RECORD, 16'h803E, PINNED, 1'b1, 16'h803F, 32'h0000_0001};
      directed_rows[20] = {srw_pkg::OP_RECORD, 16'h801F, OPEN,   1'b0, 16'h0000, 32'h0000_0000};
      directed_rows[21] = {srw_pkg::OP_QUERY,  16'hFFFF, OPEN,   1'b0, 16'h0000, 32'h0000_0000};
      directed_rows[22] = {srw_pkg::OP_RECORD, 16'h0000, PINNED, 1'b1, 16'h0000, 32'h0000_0000};
      directed_rows[23] = {srw_pkg::OP_RECORD, 16'hFFFF, PINNED, 1'b1, 16'h0000, 32'h0000_0001};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < 24; row++)
         send_req(directed_rows[row].op, directed_rows[row].seq, directed_rows[row].pinned,
                  directed_rows[row].want);
      wait_for_responses();

      send_random_traffic(PHASE_ITEMS);
      wait_for_responses();

      send_idle_pct = 69;
      rsp_stall_pct = 0;
      send_random_traffic(PHASE_ITEMS);

      send_idle_pct = 0;
      rsp_stall_pct = 69;
      send_random_traffic(PHASE_ITEMS);
      wait_for_responses();

      send_idle_pct = 18;
      rsp_stall_pct = 18;
      send_random_traffic(PHASE_ITEMS);
      wait_for_responses();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (window_reports_due.size() != 0) begin
         mismatch_count += window_reports_due.size();
         $display("%0t: %0d expected responses never arrived", $time,
                  window_reports_due.size());
      end

      $display("Covered %0d records (%0d taken as new) and %0d queries (%0d found seen),",
               record_count, accepted_count, query_count, seen_count);
      $display("under free-running, idle-sender, stalled-receiver and mixed flow control.");
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
